// ===== design/balt_pkg.sv =====
package balt_pkg;

    localparam int ADDR_W = 64;
    localparam int BANK_IN_W = 3;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_ALREADY  = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_NOT_HELD = 3'd4,
        ST_ZERO     = 3'd5
    } t_status;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic vld;
        logic hit;
        logic free;
    } t_token;

    // Write command broadcast to every cell at the end of a search or during the clearing pass.
    typedef struct packed {
        logic clear;
        logic fill;
        logic drop;
    } t_wr_cmd;

endpackage

// ===== design/balt_cell.sv =====
module balt_cell #(
    parameter int BANKS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [(BANKS > 1 ? $clog2(BANKS) : 1)-1:0] i_rd_bank,
    input  logic [balt_pkg::ADDR_W-1:0]         i_addr,
    input  balt_pkg::t_token                    i_tok,
    output balt_pkg::t_token                    o_tok,
    input  balt_pkg::t_wr_cmd                   i_wr,
    input  logic [(BANKS > 1 ? $clog2(BANKS) : 1)-1:0] i_wr_bank
);

    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;

    logic [balt_pkg::ADDR_W-1:0] r_mem [BANKS];
    logic [balt_pkg::ADDR_W-1:0] r_rd_data;
    logic                        r_mark_hit;
    logic                        r_mark_free;
    balt_pkg::t_token            r_tok;
    balt_pkg::t_token            n_tok;
    logic                        my_hit;
    logic                        my_free;
    logic                        wr_en;
    logic [balt_pkg::ADDR_W-1:0] wr_data;
    logic [BANK_W-1:0]           wr_bank;

    // First match and first empty entry claim the token in chain order.
    assign my_hit  = i_tok.vld && !i_tok.hit  && (r_rd_data == i_addr);
    assign my_free = i_tok.vld && !i_tok.free && (r_rd_data == '0);

    always_comb begin
        n_tok.vld  = i_tok.vld;
        n_tok.hit  = i_tok.hit  | my_hit;
        n_tok.free = i_tok.free | my_free;
    end

    assign wr_en   = i_wr.clear || (i_wr.fill && r_mark_free) || (i_wr.drop && r_mark_hit);
    assign wr_data = i_wr.fill ? i_addr : '0;
    assign wr_bank = i_wr_bank;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_bank] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_bank];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok       <= '0;
            r_mark_hit  <= 1'b0;
            r_mark_free <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_rd_en) begin
                r_mark_hit  <= 1'b0;
                r_mark_free <= 1'b0;
            end else begin
                if (my_hit) begin
                    r_mark_hit <= 1'b1;
                end
                if (my_free) begin
                    r_mark_free <= 1'b1;
                end
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== design/banked_address_lock_table_core.sv =====
// Banked address lock table.
//
// Input channel (i_in_valid / o_in_ready) carries one request: i_command
// (0 lock, 1 unlock), a 64-bit i_address and the i_bank it maps to. Output
// channel (o_out_valid / i_out_ready) returns one o_status per request:
// granted, already locked, bank full, released, not held or zero address.
//
// Storage is a chain of ENTRIES cells; cell k holds entry k of every bank in
// a small memory indexed by bank. A request reads its bank in all cells at
// once, then a search token walks the chain one cell per cycle, marking the
// first matching entry and the lowest empty one. When the token leaves the
// last cell the status is decided and the marked cell is written.
// One request is in flight at a time: a new request is taken only once the
// token has left the last cell and the result has been taken from the
// output register. Reset starts a clearing pass that zeroes every bank; no
// request is taken until it ends. While the receiver stalls the result
// holds in the output register and no new request is taken.
module banked_address_lock_table_core #(
    parameter int ENTRIES = 16,
    parameter int BANKS   = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_command,
    input  logic [balt_pkg::ADDR_W-1:0]      i_address,
    input  logic [balt_pkg::BANK_IN_W-1:0]   i_bank,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_status
);

    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WALK  = 3'b100
    } t_state;

    t_state                             r_state;
    t_state                             n_state;
    logic                               r_cmd;
    logic [balt_pkg::ADDR_W-1:0]        r_addr;
    logic [balt_pkg::BANK_IN_W-1:0]     r_bank;
    logic                               r_inject;
    logic [BANK_W-1:0]                  r_clr_cnt;
    logic                               r_out_valid;
    balt_pkg::t_status                  r_status;
    balt_pkg::t_status                  n_status;

    balt_pkg::t_token                   tok [ENTRIES+1];
    balt_pkg::t_wr_cmd                  wr;
    logic [BANK_W-1:0]                  wr_bank;
    logic                               in_xfer;
    logic                               out_xfer;
    logic                               done;
    logic                               bank_ok;
    logic                               clr_last;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;
    assign done     = (r_state == S_WALK) && tok[ENTRIES].vld;
    assign bank_ok  = (32'(r_bank) < BANKS);
    assign clr_last = (r_clr_cnt == BANK_W'(BANKS - 1));

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    // Inject a fresh token into the head of the chain.
    assign tok[0] = {r_inject, 1'b0, 1'b0};

    // Decide the status from the token leaving the last cell.
    always_comb begin
        n_status = balt_pkg::ST_NOT_HELD;
        wr.fill  = 1'b0;
        wr.drop  = 1'b0;
        priority if (r_addr == '0) begin
            n_status = balt_pkg::ST_ZERO;
        end else if (!r_cmd) begin
            priority if (!bank_ok) begin
                n_status = balt_pkg::ST_FULL;
            end else if (tok[ENTRIES].hit) begin
                n_status = balt_pkg::ST_ALREADY;
            end else if (tok[ENTRIES].free) begin
                n_status = balt_pkg::ST_GRANTED;
                wr.fill  = done;
            end else begin
                n_status = balt_pkg::ST_FULL;
            end
        end else begin
            priority if (bank_ok && tok[ENTRIES].hit) begin
                n_status = balt_pkg::ST_RELEASED;
                wr.drop  = done;
            end else begin
                n_status = balt_pkg::ST_NOT_HELD;
            end
        end
        wr.clear = (r_state == S_CLEAR);
    end

    assign wr_bank = (r_state == S_CLEAR) ? r_clr_cnt : BANK_W'(r_bank);

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        balt_cell #(
            .BANKS(BANKS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_rd_en   (in_xfer),
            .i_rd_bank (BANK_W'(i_bank)),
            .i_addr    (r_addr),
            .i_tok     (tok[g]),
            .o_tok     (tok[g+1]),
            .i_wr      (wr),
            .i_wr_bank (wr_bank)
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (clr_last) n_state = S_IDLE;
            S_IDLE:  if (in_xfer) n_state = S_WALK;
            S_WALK:  if (done) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Hold the request while the token walks, and capture the status when it leaves the last cell.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_command;
            r_addr <= i_address;
            r_bank <= i_bank;
        end
        if (done) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= in_xfer;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
